FILE: hdl/sha_pkg.sv
// package: constants, address map, mode codes and round tables for the hash accelerator
package sha_pkg;

    localparam int MSG_WORDS_DEF  = 32;
    localparam int HASH_WORDS_DEF = 16;

    localparam logic [5:0] ADDR_MSG     = 6'd16;
    localparam logic [5:0] ADDR_MODE    = 6'd48;
    localparam logic [5:0] ADDR_START   = 6'd49;
    localparam logic [5:0] ADDR_CONT    = 6'd50;
    localparam logic [5:0] ADDR_BUSY    = 6'd51;
    localparam logic [5:0] ADDR_VERSION = 6'd52;
    localparam logic [31:0] VERSION_WORD = 32'h2019_0402;

    localparam logic [2:0] MODE_SHA1   = 3'd0;
    localparam logic [2:0] MODE_SHA224 = 3'd1;
    localparam logic [2:0] MODE_SHA256 = 3'd2;
    localparam logic [2:0] MODE_SHA384 = 3'd3;
    localparam logic [2:0] MODE_NONE   = 3'd7;

    localparam logic REQ_WRITE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       load;      // load working state and schedule
        logic       from_iv;   // load from initial value, else from hash words
        logic       round;     // run one round
        logic [6:0] rnd;       // round index
        logic       finish;    // add and store back
    } t_sha_cmd;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [63:0] k64(input logic [6:0] i);
        logic [63:0] k [80];
        k = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return (i < 7'd80) ? k[i] : 64'd0;
    endfunction

    // initial value as sixteen 32-bit words in state order
    function automatic logic [31:0] iv_word(input logic [2:0] m, input logic [3:0] i);
        logic [63:0] v;
        logic [31:0] w;
        v = 64'd0;
        w = 32'd0;
        case (m)
            3'd0: case (i)
                4'd0: w = 32'h67452301; 4'd1: w = 32'hefcdab89; 4'd2: w = 32'h98badcfe;
                4'd3: w = 32'h10325476; 4'd4: w = 32'hc3d2e1f0; default: w = 32'd0;
            endcase
            3'd1: case (i)
                4'd0: w = 32'hc1059ed8; 4'd1: w = 32'h367cd507; 4'd2: w = 32'h3070dd17;
                4'd3: w = 32'hf70e5939; 4'd4: w = 32'hffc00b31; 4'd5: w = 32'h68581511;
                4'd6: w = 32'h64f98fa7; 4'd7: w = 32'hbefa4fa4; default: w = 32'd0;
            endcase
            3'd2: case (i)
                4'd0: w = 32'h6a09e667; 4'd1: w = 32'hbb67ae85; 4'd2: w = 32'h3c6ef372;
                4'd3: w = 32'ha54ff53a; 4'd4: w = 32'h510e527f; 4'd5: w = 32'h9b05688c;
                4'd6: w = 32'h1f83d9ab; 4'd7: w = 32'h5be0cd19; default: w = 32'd0;
            endcase
            default: begin
                case ({m, i[3:1]})
                    6'o30: v = 64'hcbbb9d5dc1059ed8; 6'o31: v = 64'h629a292a367cd507;
                    6'o32: v = 64'h9159015a3070dd17; 6'o33: v = 64'h152fecd8f70e5939;
                    6'o34: v = 64'h67332667ffc00b31; 6'o35: v = 64'h8eb44a8768581511;
                    6'o36: v = 64'hdb0c2e0d64f98fa7; 6'o37: v = 64'h47b5481dbefa4fa4;
                    6'o40: v = 64'h6a09e667f3bcc908; 6'o41: v = 64'hbb67ae8584caa73b;
                    6'o42: v = 64'h3c6ef372fe94f82b; 6'o43: v = 64'ha54ff53a5f1d36f1;
                    6'o44: v = 64'h510e527fade682d1; 6'o45: v = 64'h9b05688c2b3e6c1f;
                    6'o46: v = 64'h1f83d9abfb41bd6b; 6'o47: v = 64'h5be0cd19137e2179;
                    6'o50: v = 64'h8c3d37c819544da2; 6'o51: v = 64'h73e1996689dcd4d6;
                    6'o52: v = 64'h1dfab7ae32ff9c82; 6'o53: v = 64'h679dd514582f9fcf;
                    6'o54: v = 64'h0f6d2b697bd44da8; 6'o55: v = 64'h77e36f7304c48942;
                    6'o56: v = 64'h3f9d85a86a1d36c8; 6'o57: v = 64'h1112e6ad91d692a1;
                    6'o60: v = 64'h22312194fc2bf72c; 6'o61: v = 64'h9f555fa3c84c64c2;
                    6'o62: v = 64'h2393b86b6f53b151; 6'o63: v = 64'h963877195940eabd;
                    6'o64: v = 64'h96283ee2a88effe3; 6'o65: v = 64'hbe5e1e2553863992;
                    6'o66: v = 64'h2b0199fc2c85b8aa; 6'o67: v = 64'h0eb72ddc81c52ca2;
                    default: v = 64'd0;
                endcase
                w = i[0] ? v[31:0] : v[63:32];
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/sha_if.sv
// valid/ready channel interface carrying one bus word
interface sha_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [5:0]  word_addr;
    logic [31:0] write_data;
    modport source (output valid, req_type, word_addr, write_data, input ready);
    modport sink   (input valid, req_type, word_addr, write_data, output ready);
endinterface

interface sha_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

FILE: hdl/sha_multi_mode_register_accelerator_core.sv
// top level: register-mapped sha-1 / sha-2 hash accelerator
//
//  channel | dir | fields                            | taken when
//  i_req   | in  | req_type, word_addr, write_data   | valid && ready
//  o_rsp   | out | read_data                         | valid && ready
//
// the response word sits in an output register
// a start or continue trigger runs a load step, 64 (sha-224/256) or 80 rounds and a store
// step, one round per cycle in the shared round unit
// i_req.ready is low while a compression runs (load, rounds, store) or the response register is full and not being read
// reset is synchronous, active low; hash, message and mode registers clear to zero
module sha_multi_mode_register_accelerator_core
    import sha_pkg::*;
#(
    parameter int MSG_WORDS  = MSG_WORDS_DEF,
    parameter int HASH_WORDS = HASH_WORDS_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_req_if.sink    i_req,
    sha_rsp_if.source  o_rsp
);
    t_sha_cmd    cmd;
    logic        busy;
    logic        acc;
    logic [31:0] rd;
    logic [2:0]  mode;
    logic        go, trig;
    logic        r_valid;
    logic [31:0] r_data;

    // accept a word when the engine is idle and the response slot is empty or frees this cycle
    assign i_req.ready = !busy && (!r_valid || o_rsp.ready);
    assign acc = i_req.valid && i_req.ready;

    // trigger: start or continue with bit 0 set, ignored in the unsupported mode
    assign trig = (i_req.word_addr == ADDR_START) || (i_req.word_addr == ADDR_CONT);
    assign go = acc && (i_req.req_type == REQ_WRITE) && trig && i_req.write_data[0]
                && (mode != MODE_NONE);

    sha_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_from_iv (i_req.word_addr == ADDR_START),
        .i_wide    (mode >= MODE_SHA384),
        .i_sha1    (mode == MODE_SHA1),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    sha_dp #(
        .MSG_WORDS  (MSG_WORDS),
        .HASH_WORDS (HASH_WORDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_req_type   (i_req.req_type),
        .i_word_addr  (i_req.word_addr),
        .i_write_data (i_req.write_data),
        .i_cmd        (cmd),
        .o_read_data  (rd),
        .o_mode       (mode)
    );

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_data <= rd;
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.read_data = r_data;
endmodule

FILE: hdl/sha_ctrl.sv
// controller: sequences load, rounds and store-back of one compression
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic       i_from_iv,
    input  logic       i_wide,
    input  logic       i_sha1,
    output t_sha_cmd   o_cmd,
    output logic       o_busy
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [6:0] r_rnd, n_rnd;
    logic       r_iv, n_iv;
    logic [6:0] last;

    assign last = (i_wide || i_sha1) ? 7'd79 : 7'd63;

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_iv    = r_iv;
        unique case (r_state)
            S_IDLE: if (i_go) begin
                n_state = S_LOAD;
                n_iv    = i_from_iv;
            end
            S_LOAD: begin
                n_state = S_RUN;
                n_rnd   = 7'd0;
            end
            S_RUN: begin
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == last) n_state = S_FIN;
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= 7'd0;
            r_iv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_iv    <= n_iv;
        end
    end

    always_comb begin
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.from_iv = r_iv;
        o_cmd.round   = (r_state == S_RUN);
        o_cmd.rnd     = r_rnd;
        o_cmd.finish  = (r_state == S_FIN);
    end
    assign o_busy = (r_state != S_IDLE);
endmodule

FILE: hdl/sha_dp.sv
// datapath: register file, message schedule window and one-round compression unit
module sha_dp
    import sha_pkg::*;
#(
    parameter int MSG_WORDS  = MSG_WORDS_DEF,
    parameter int HASH_WORDS = HASH_WORDS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  logic        i_req_type,
    input  logic [5:0]  i_word_addr,
    input  logic [31:0] i_write_data,
    input  t_sha_cmd    i_cmd,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_mode
);
    logic [31:0] r_hash [HASH_WORDS];
    logic [31:0] r_msg  [MSG_WORDS];
    logic [2:0]  r_mode;
    logic [63:0] r_chain [8];
    logic [63:0] r_s [8];
    logic [63:0] r_w [16];

    logic wide, sha1;
    assign wide = (r_mode >= MODE_SHA384);
    assign sha1 = (r_mode == MODE_SHA1);
    assign o_mode = r_mode;

    function automatic logic [31:0] hget(input int i);
        return (i < HASH_WORDS) ? r_hash[i] : 32'd0;
    endfunction
    function automatic logic [31:0] mbe(input int i);
        return (i < MSG_WORDS) ? swap32(r_msg[i]) : 32'd0;
    endfunction

    // load values
    logic [63:0] ld_s [8];
    logic [63:0] ld_w [16];
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (wide) begin
                ld_s[i] = i_cmd.from_iv ?
                    {iv_word(r_mode, 4'(2*i)), iv_word(r_mode, 4'(2*i+1))} :
                    {hget(2*i), hget(2*i+1)};
            end else begin
                ld_s[i] = {32'd0, i_cmd.from_iv ? iv_word(r_mode, 4'(i)) : hget(i)};
            end
        end
        for (int i = 0; i < 16; i++) begin
            ld_w[i] = wide ? {mbe(2*i), mbe(2*i+1)} : {32'd0, mbe(i)};
        end
    end

    // one round
    logic [63:0] wt, nw, e1, ch, e0, mj, t1, t2, f1, k1, t1s;
    logic [63:0] rs [8];
    logic [31:0] a, b, c, d, e, x;
    logic [63:0] kk;
    always_comb begin
        wt = r_w[0];
        kk = k64(i_cmd.rnd);
        a = r_s[0][31:0]; b = r_s[1][31:0]; c = r_s[2][31:0]; d = r_s[3][31:0];
        e = r_s[4][31:0];
        x = r_w[13][31:0] ^ r_w[8][31:0] ^ r_w[2][31:0] ^ r_w[0][31:0];
        e1 = '0; ch = '0; e0 = '0; mj = '0; t1 = '0; t2 = '0; f1 = '0; k1 = '0;
        t1s = '0;
        for (int i = 0; i < 8; i++) rs[i] = r_s[i];
        if (sha1) begin
            nw = {32'd0, x[30:0], x[31]};
            if (i_cmd.rnd < 7'd20) begin
                f1 = {32'd0, (b & c) | (~b & d)}; k1 = 64'h5a827999;
            end else if (i_cmd.rnd < 7'd40) begin
                f1 = {32'd0, b ^ c ^ d}; k1 = 64'h6ed9eba1;
            end else if (i_cmd.rnd < 7'd60) begin
                f1 = {32'd0, (b & c) | (b & d) | (c & d)}; k1 = 64'h8f1bbcdc;
            end else begin
                f1 = {32'd0, b ^ c ^ d}; k1 = 64'hca62c1d6;
            end
            t1s = {32'd0, 32'({a[26:0], a[31:27]} + f1[31:0] + e + k1[31:0] + wt[31:0])};
            rs[0] = t1s; rs[1] = {32'd0, a}; rs[2] = {32'd0, b[1:0], b[31:2]};
            rs[3] = {32'd0, c}; rs[4] = {32'd0, d};
        end else if (wide) begin
            nw = r_w[0] + ({r_w[1][0], r_w[1][63:1]} ^ {r_w[1][7:0], r_w[1][63:8]}
                 ^ (r_w[1] >> 7)) + r_w[9]
                 + ({r_w[14][18:0], r_w[14][63:19]} ^ {r_w[14][60:0], r_w[14][63:61]}
                 ^ (r_w[14] >> 6));
            e1 = {r_s[4][13:0], r_s[4][63:14]} ^ {r_s[4][17:0], r_s[4][63:18]}
                 ^ {r_s[4][40:0], r_s[4][63:41]};
            ch = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
            t1 = r_s[7] + e1 + ch + kk + wt;
            e0 = {r_s[0][27:0], r_s[0][63:28]} ^ {r_s[0][33:0], r_s[0][63:34]}
                 ^ {r_s[0][38:0], r_s[0][63:39]};
            mj = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
            t2 = e0 + mj;
            for (int i = 7; i > 0; i--) rs[i] = r_s[i-1];
            rs[4] = r_s[3] + t1;
            rs[0] = t1 + t2;
        end else begin
            nw = {32'd0, 32'(r_w[0][31:0]
                 + ({r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]}
                 ^ (r_w[1][31:0] >> 3)) + r_w[9][31:0]
                 + ({r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
                 ^ (r_w[14][31:0] >> 10)))};
            e1[31:0] = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
            ch[31:0] = (e & r_s[5][31:0]) ^ (~e & r_s[6][31:0]);
            t1[31:0] = r_s[7][31:0] + e1[31:0] + ch[31:0] + kk[63:32] + wt[31:0];
            e0[31:0] = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
            mj[31:0] = (a & b) ^ (a & c) ^ (b & c);
            t2[31:0] = e0[31:0] + mj[31:0];
            for (int i = 7; i > 0; i--) rs[i] = r_s[i-1];
            rs[4] = {32'd0, 32'(d + t1[31:0])};
            rs[0] = {32'd0, 32'(t1[31:0] + t2[31:0])};
        end
    end

    // final chaining value
    logic [63:0] fin [8];
    always_comb begin
        for (int i = 0; i < 8; i++)
            fin[i] = wide ? r_chain[i] + r_s[i] : {32'd0, 32'(r_chain[i][31:0] + r_s[i][31:0])};
    end

    logic [5:0] midx;
    assign midx = i_word_addr - ADDR_MSG;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SHA1;
            for (int i = 0; i < HASH_WORDS; i++) r_hash[i] <= '0;
            for (int i = 0; i < MSG_WORDS; i++) r_msg[i] <= '0;
        end else begin
            if (i_acc && i_req_type == REQ_WRITE) begin
                if (i_word_addr < ADDR_MSG) begin
                    if (int'(i_word_addr) < HASH_WORDS)
                        r_hash[i_word_addr[$clog2(HASH_WORDS)-1:0]] <= swap32(i_write_data);
                end else if (i_word_addr < ADDR_MODE) begin
                    if (int'(midx) < MSG_WORDS)
                        r_msg[midx[$clog2(MSG_WORDS)-1:0]] <= i_write_data;
                end else if (i_word_addr == ADDR_MODE) begin
                    r_mode <= i_write_data[2:0];
                end
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < 8; i++) begin
                    if (wide) begin
                        if (2*i < HASH_WORDS) r_hash[2*i] <= fin[i][63:32];
                        if (2*i+1 < HASH_WORDS) r_hash[2*i+1] <= fin[i][31:0];
                    end else if (i < HASH_WORDS && (!sha1 || i < 5)) begin
                        r_hash[i] <= fin[i][31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= ld_s[i];
                r_s[i]     <= ld_s[i];
            end
            for (int i = 0; i < 16; i++) r_w[i] <= ld_w[i];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 8; i++) r_s[i] <= rs[i];
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= nw;
        end
    end

    always_comb begin
        o_read_data = 32'd0;
        if (i_word_addr < ADDR_MSG) begin
            o_read_data = swap32(hget(int'(i_word_addr)));
        end else if (i_word_addr < ADDR_MODE) begin
            o_read_data = (int'(midx) < MSG_WORDS) ? r_msg[midx[$clog2(MSG_WORDS)-1:0]] : 32'd0;
        end else if (i_word_addr == ADDR_MODE) begin
            o_read_data = {29'd0, r_mode};
        end else if (i_word_addr == ADDR_VERSION) begin
            o_read_data = VERSION_WORD;
        end
        if (i_req_type == REQ_WRITE) o_read_data = 32'd0;
    end
endmodule
